/* hdl/epsilon_neighbourhood_query_top_defines.svh */
// Assertion macros for the epsilon neighbourhood query block.
`ifndef EPSILON_NEIGHBOURHOOD_QUERY_TOP_DEFINES_SVH
`define EPSILON_NEIGHBOURHOOD_QUERY_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define ENQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ENQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/enq_pkg.sv */
// Package with shared types and constants of the epsilon neighbourhood query block.
package enq_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DIM_DEF        = 4;
    localparam int COORD_W        = 16;
    localparam int EPS_W          = 16;
    localparam int CNT_W          = 7;
    localparam int IDX_W          = 6;
    localparam int DSEL_W         = 2;
    localparam int SQ_W           = 34;
    localparam int DIST_W         = 40;
    localparam int ADDR_W         = 1;

    localparam logic [15:0] EPS_RESET   = 16'd256;
    localparam logic [6:0]  COUNT_RESET = 7'd64;

    localparam logic [ADDR_W-1:0] REG_EPS   = 1'b0;
    localparam logic [ADDR_W-1:0] REG_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  point_index;
        logic [DSEL_W-1:0] dim_index;
        logic signed [COORD_W-1:0] coord;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] neighbour_index;
        logic             last_neighbour;
        logic             index_error;
    } out_beat_t;

    // Broadcast from sequencer into the cell row.
    typedef struct packed {
        logic              load;
        logic [IDX_W-1:0]  load_point;
        logic [DSEL_W-1:0] load_dim;
        logic [COORD_W-1:0] load_coord;
    } load_cmd_t;

endpackage

/* hdl/enq_cell.sv */
// One point cell: holds a point's coordinates and shifts them around the ring.
module enq_cell #(
    parameter int DIM = enq_pkg::DIM_DEF
) (
    input  logic                                aclk,
    input  logic                                load_en,
    input  logic [enq_pkg::DSEL_W-1:0]          load_dim,
    input  logic [enq_pkg::COORD_W-1:0]         load_coord,
    input  logic                                shift_en,
    input  logic [DIM-1:0][enq_pkg::COORD_W-1:0] prev_coords,
    output logic [DIM-1:0][enq_pkg::COORD_W-1:0] coords
);

    logic [DIM-1:0][enq_pkg::COORD_W-1:0] coord_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            coord_reg <= prev_coords;
        end else if (load_en) begin
            for (int d = 0; d < DIM; d++) begin
                if (load_dim == d[enq_pkg::DSEL_W-1:0]) begin
                    coord_reg[d] <= load_coord;
                end
            end
        end
    end

    assign coords = coord_reg;

endmodule

/* hdl/enq_dist.sv */
// Squared distance unit: registered squares, then a registered compare of their sum against eps squared.
module enq_dist #(
    parameter int DIM = enq_pkg::DIM_DEF
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [DIM-1:0][enq_pkg::COORD_W-1:0] centre,
    input  logic [DIM-1:0][enq_pkg::COORD_W-1:0] other,
    input  logic [enq_pkg::EPS_W-1:0]            eps,
    output logic                                 near
);

    logic [DIM-1:0][31:0] sq_reg;
    logic [31:0]          eps2_reg;
    logic                 near_reg;
    logic [enq_pkg::DIST_W-1:0] sum;

    // Both stages hold while en is low so results stay lined up with their tags.
    always_ff @(posedge aclk) begin
        eps2_reg <= 32'(eps) * 32'(eps);
        if (en) begin
            for (int d = 0; d < DIM; d++) begin
                logic signed [16:0] diff;
                logic [15:0] mag;
                diff = $signed({centre[d][15], centre[d]}) - $signed({other[d][15], other[d]});
                // |diff| is at most 65535, so 16 bits hold the magnitude.
                mag  = diff[16] ? 16'(-diff) : 16'(diff);
                sq_reg[d] <= 32'(mag) * 32'(mag);
            end
            near_reg <= (sum <= {8'd0, eps2_reg});
        end
    end

    always_comb begin
        sum = '0;
        for (int d = 0; d < DIM; d++) begin
            sum = sum + enq_pkg::DIST_W'(sq_reg[d]);
        end
    end

    assign near = near_reg;

endmodule

/* hdl/epsilon_neighbourhood_query_top.sv */
// Top level of the epsilon neighbourhood query block.
//   channel | direction | beat type   | handshake
//   s_      | in        | in_beat_t   | s_valid / s_ready
//   m_      | out       | out_beat_t  | m_valid / m_ready
//   apb     | in        | 32-bit regs | psel / penable, pready tied high
// A query rotates the ring of point cells once, through every cell, then drains
// while the two-stage distance pipeline empties; ring, tags and distance pipeline
// all freeze while a result waits on m_ready.
// The final beat of a query is offered the cycle after the drain ends.
// An out-of-range query gives its error beat in the cycle after it is accepted.
// s_ready is low while a query runs or while a result waits on m_ready.
// Reset (aresetn low, synchronous) clears control and restores eps and count.
`include "epsilon_neighbourhood_query_top_defines.svh"
module epsilon_neighbourhood_query_top #(
    parameter int MAX_POINTS = enq_pkg::MAX_POINTS_DEF,
    parameter int DIM        = enq_pkg::DIM_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  enq_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output enq_pkg::out_beat_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = PW + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    state_t state_reg;
    logic [15:0] eps_reg;
    logic [6:0]  count_reg;
    logic [CW-1:0] step_reg;     // shifts done
    logic [CW-1:0] eff_count;
    logic [1:0][CW-1:0] tag_reg; // pipeline index tags
    logic [1:0] tv_reg;          // pipeline valid
    logic [DIM-1:0][15:0] centre_reg;
    logic pend_reg;              // a hit is held waiting for a later one
    logic [PW-1:0] pend_idx_reg;
    logic m_valid_reg;
    enq_pkg::out_beat_t m_data_reg;

    logic [MAX_POINTS-1:0][DIM-1:0][15:0] ring;
    logic near;
    logic adv;
    logic s_acc;
    logic err_q;
    logic hit;
    logic flush;
    logic emit;
    logic [CW-1:0] hit_idx;

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            enq_pkg::REG_EPS:   prdata = {16'd0, eps_reg};
            enq_pkg::REG_COUNT: prdata = {25'd0, count_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg   <= enq_pkg::EPS_RESET;
            count_reg <= enq_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == enq_pkg::REG_EPS) eps_reg <= pwdata[15:0];
            else count_reg <= pwdata[6:0];
        end
    end

    assign eff_count = (count_reg > 7'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_reg);

    // Ring advances only when the output can absorb a result.
    assign adv   = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && adv;
    assign s_acc = s_valid && s_ready;
    assign err_q = s_acc && s_data.op == enq_pkg::OP_QUERY
                   && 7'(s_data.point_index) >= 7'(eff_count);

    // Ring of cells: cell i receives cell i+1, the last cell receives cell 0.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        enq_cell #(.DIM(DIM)) u_cell (
            .aclk        (aclk),
            .load_en     (s_acc && s_data.op == enq_pkg::OP_LOAD
                          && s_data.point_index == 6'(i)
                          && 32'(s_data.dim_index) < DIM),
            .load_dim    (s_data.dim_index),
            .load_coord  (s_data.coord),
            .shift_en    (state_reg == ST_RUN && adv),
            .prev_coords (ring[(i + 1) % MAX_POINTS]),
            .coords      (ring[i])
        );
    end

    // Squares are taken at the edge that ends step s (ring[0] holds point s),
    // so the compare result lines up with tag stage 1.
    enq_dist #(.DIM(DIM)) u_dist (
        .aclk   (aclk),
        .en     (adv),
        .centre (centre_reg),
        .other  (ring[0]),
        .eps    (eps_reg),
        .near   (near)
    );

    assign hit_idx = tag_reg[1];
    assign hit     = tv_reg[1] && near;
    // Drain done: nothing valid left in the pipe, so the pending hit is the last.
    assign flush   = (state_reg == ST_DRAIN) && !tv_reg[0] && !hit;
    assign emit    = err_q
                     || (adv && state_reg != ST_IDLE && ((hit && pend_reg) || flush));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tv_reg      <= '0;
            pend_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && !emit) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (err_q) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{neighbour_index: '0, last_neighbour: 1'b1,
                                         index_error: 1'b1};
                    end else if (s_acc && s_data.op == enq_pkg::OP_QUERY) begin
                        // Ring is unrotated here, so the centre is read in place.
                        state_reg  <= ST_RUN;
                        step_reg   <= '0;
                        centre_reg <= ring[s_data.point_index[PW-1:0]];
                        tv_reg     <= '0;
                        pend_reg   <= 1'b0;
                    end
                end
                ST_RUN, ST_DRAIN: begin
                    if (adv) begin
                        if (state_reg == ST_RUN) begin
                            // Slot 0 holds point step_reg.
                            tv_reg   <= {tv_reg[0], (step_reg < eff_count)};
                            step_reg <= step_reg + 1'b1;
                            if (step_reg == CW'(MAX_POINTS - 1)) state_reg <= ST_DRAIN;
                        end else begin
                            tv_reg <= {tv_reg[0], 1'b0};
                        end
                        tag_reg <= {tag_reg[0], step_reg};
                        // Hold a hit until the next hit or the end is known.
                        if (hit) begin
                            if (pend_reg) begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '{neighbour_index: 6'(pend_idx_reg),
                                                 last_neighbour: 1'b0, index_error: 1'b0};
                            end
                            pend_reg     <= 1'b1;
                            pend_idx_reg <= hit_idx[PW-1:0];
                        end
                        if (flush) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{neighbour_index: 6'(pend_idx_reg),
                                             last_neighbour: 1'b1, index_error: 1'b0};
                            pend_reg    <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ENQ_ASSERT_IMPL(a_busy_no_accept, state_reg != ST_IDLE, !s_ready,
        "input accepted during a query")
    `ENQ_ASSERT_NEXT(a_err_beat, err_q,
        m_valid && m_data.index_error && m_data.last_neighbour,
        "out-of-range query gave no error beat")
    `ENQ_ASSERT_IMPL(a_hold_out, m_valid && !m_ready, state_reg == ST_IDLE || !adv,
        "ring advanced while a result was held")

endmodule
